FILE: rtl/sali_pkg.sv
// Shared types and constants of the sensor average level indicator.
// Used by the channel interfaces and the top level; depends on nothing.
package sali_pkg;

  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned SWITCH_W  = 8;
  localparam int unsigned SELECT_W  = 3;
  localparam int unsigned VALUE_W   = 15;
  localparam int unsigned BAR_W     = 8;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned SHOWN_W   = 14;
  localparam int unsigned THRESH_W  = 10;
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned SCALE_W   = 7;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 5;

  localparam logic [SAMPLE_W-1:0] SAMPLE_NONE = 8'h00;
  localparam logic [SAMPLE_W-1:0] SAMPLE_SAT  = 8'hff;
  localparam logic [SCALE_W-1:0]  BLOCK_SCALE = 7'd100;
  localparam logic [VALUE_W-1:0]  MIN_RESET   = 15'd1000;
  localparam logic [SHOWN_W-1:0]  SHOW_LIMIT  = 14'd9999;

  localparam logic [THRESH_W-1:0] THR_LOW_RESET   = 10'd250;
  localparam logic [THRESH_W-1:0] THR_MID_RESET   = 10'd500;
  localparam logic [THRESH_W-1:0] THR_HIGH_RESET  = 10'd750;
  localparam logic [VALUE_W-1:0]  UPPER_LIM_RESET = 15'd1000;

  // Bar patterns and the digits they show as.
  localparam logic [BAR_W-1:0] BAR_OFF   = 8'h00;
  localparam logic [BAR_W-1:0] BAR_ONE   = 8'h01;
  localparam logic [BAR_W-1:0] BAR_THREE = 8'h03;
  localparam logic [BAR_W-1:0] BAR_SEVEN = 8'h07;

  localparam logic [LEVEL_W-1:0] DIGIT_OFF   = 2'd0;
  localparam logic [LEVEL_W-1:0] DIGIT_ONE   = 2'd1;
  localparam logic [LEVEL_W-1:0] DIGIT_THREE = 2'd2;
  localparam logic [LEVEL_W-1:0] DIGIT_SEVEN = 2'd3;

  typedef enum logic [2:0] {
    REG_THR_LOW   = 3'd0,
    REG_THR_MID   = 3'd1,
    REG_THR_HIGH  = 3'd2,
    REG_UPPER_LIM = 3'd3,
    REG_MANUAL    = 3'd4
  } reg_idx_t;

endpackage

FILE: rtl/sali_in_if.sv
// Input channel of the level indicator: valid/ready handshake with one sensor item.
// Depends on sali_pkg for the field widths.
interface sali_in_if import sali_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [SWITCH_W-1:0] manual_switches;
  logic [SELECT_W-1:0] display_select;

  modport source (output valid, sample, manual_switches, display_select, input ready);
  modport sink   (input valid, sample, manual_switches, display_select, output ready);
endinterface

FILE: rtl/sali_out_if.sv
// Result channel of the level indicator: valid/ready handshake with one block result.
// Depends on sali_pkg for the field widths.
interface sali_out_if import sali_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] sensor_value;
  logic [BAR_W-1:0]   level_bar;
  logic               lamp_on;
  logic               mode_digit;
  logic [LEVEL_W-1:0] level_digit;
  logic [SHOWN_W-1:0] shown_number;

  modport source (output valid, sensor_value, level_bar, lamp_on, mode_digit, level_digit,
                  shown_number, input ready);
  modport sink   (input valid, sensor_value, level_bar, lamp_on, mode_digit, level_digit,
                  shown_number, output ready);
endinterface

FILE: rtl/sensor_average_level_indicator_unit.sv
// Top level of the sensor average level indicator: input register, block logic,
// result register and APB register file. Depends on sali_pkg, sali_in_if, sali_out_if.
//
//   channel   direction  handshake            payload
//   in_ch     in         valid/ready          sample, manual_switches, display_select
//   out_ch    out        valid/ready          sensor_value, level_bar, lamp_on,
//                                             mode_digit, level_digit, shown_number
//   APB       in         psel/penable/pready  5 registers at byte address 4*i
//
// One item per cycle unless a stalled sink holds a result: an accepted item is held
// in the input register, and the block logic then updates the state and, on the last
// valid sample of a block, loads the result register, which drives the result valid.
// A result held by a stalled sink freezes the block state and the input register,
// so in_ready drops once the input register is full; rst_n clears control and state.
module sensor_average_level_indicator_unit
  import sali_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_AVERAGE = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  sali_in_if.sink           in_ch,
  sali_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CNT_W    = $clog2(SAMPLES_PER_AVERAGE);
  // The block value sum * 100 / N is a multiply by a rounded-up reciprocal. With
  // 20 fraction bits the truncated result is exact for any 12-bit sum and N up to 16.
  localparam int unsigned RECIP_SH = 20;
  localparam int unsigned RECIP_W  = 26;
  localparam int unsigned PROD_W   = RECIP_SH + VALUE_W;
  localparam longint unsigned RECIP =
    ((64'(BLOCK_SCALE) << RECIP_SH) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  // Configuration registers.
  logic [THRESH_W-1:0] thr_low_r, thr_mid_r, thr_high_r;
  logic [VALUE_W-1:0]  upper_lim_r;
  logic                manual_r;

  // Input register.
  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [SWITCH_W-1:0] s1_switch_r;
  logic [SELECT_W-1:0] s1_select_r;

  // Block state.
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [VALUE_W-1:0] min_r, min_nxt;
  logic [VALUE_W-1:0] max_r, max_nxt;
  logic [BAR_W-1:0]   bar_r, bar_nxt;
  logic               lamp_r, lamp_nxt;
  logic [LEVEL_W-1:0] digit_r, digit_nxt;
  logic [SHOWN_W-1:0] disp_r, disp_nxt;

  // Result register.
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;

  logic               s2_go;
  logic               sample_ok;
  logic               block_done;
  logic [SUM_W-1:0]   sum_add;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] value;
  logic               below_low;
  logic [VALUE_W-1:0] thr_low_x, thr_mid_x, thr_high_x;
  logic               wr_en;
  logic [2:0]         reg_idx;

  function automatic logic [SHOWN_W-1:0] sat_show(input logic [VALUE_W-1:0] v);
    if (v > VALUE_W'(SHOW_LIMIT)) begin
      return SHOW_LIMIT;
    end
    return v[SHOWN_W-1:0];
  endfunction

  // ---------------- APB register file ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_THR_LOW:   prdata = APB_DW'(thr_low_r);
      REG_THR_MID:   prdata = APB_DW'(thr_mid_r);
      REG_THR_HIGH:  prdata = APB_DW'(thr_high_r);
      REG_UPPER_LIM: prdata = APB_DW'(upper_lim_r);
      REG_MANUAL:    prdata = APB_DW'(manual_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_low_r   <= THR_LOW_RESET;
      thr_mid_r   <= THR_MID_RESET;
      thr_high_r  <= THR_HIGH_RESET;
      upper_lim_r <= UPPER_LIM_RESET;
      manual_r    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THR_LOW:   thr_low_r   <= pwdata[THRESH_W-1:0];
        REG_THR_MID:   thr_mid_r   <= pwdata[THRESH_W-1:0];
        REG_THR_HIGH:  thr_high_r  <= pwdata[THRESH_W-1:0];
        REG_UPPER_LIM: upper_lim_r <= pwdata[VALUE_W-1:0];
        REG_MANUAL:    manual_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- Handshake ----------------
  // The block logic may run whenever the result register is free or being emptied.
  assign s2_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s2_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample_r <= in_ch.sample;
      s1_switch_r <= in_ch.manual_switches;
      s1_select_r <= in_ch.display_select;
    end
  end

  // ---------------- Block logic ----------------
  assign sample_ok  = (s1_sample_r != SAMPLE_NONE) && (s1_sample_r != SAMPLE_SAT);
  assign sum_add    = sum_r + SUM_W'(s1_sample_r);
  assign block_done = sample_ok && (cnt_r == CNT_LAST);
  assign prod       = PROD_W'(sum_add) * PROD_W'(RECIP);
  assign value      = prod[RECIP_SH +: VALUE_W];
  assign thr_low_x  = VALUE_W'(thr_low_r);
  assign thr_mid_x  = VALUE_W'(thr_mid_r);
  assign thr_high_x = VALUE_W'(thr_high_r);
  assign below_low  = value < thr_low_x;

  always_comb begin
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    bar_nxt   = bar_r;
    lamp_nxt  = lamp_r;
    digit_nxt = digit_r;
    disp_nxt  = disp_r;
    if (sample_ok && !block_done) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      sum_nxt = sum_add;
    end else if (block_done) begin
      cnt_nxt = '0;
      sum_nxt = '0;
      if (value < min_r) min_nxt = value;
      if (value > max_r) max_nxt = value;
      lamp_nxt = !below_low;
      if (manual_r) begin
        bar_nxt = s1_switch_r;
        // Switch patterns that are valid bar codes also set the lamp: off for BAR_OFF, on for the others.
        if (s1_switch_r == BAR_OFF) begin
          lamp_nxt = 1'b0;
        end else if (s1_switch_r == BAR_ONE || s1_switch_r == BAR_THREE ||
                     s1_switch_r == BAR_SEVEN) begin
          lamp_nxt = 1'b1;
        end
      end else begin
        // Above both the high threshold and the upper limit the previous bar is kept.
        if (below_low) begin
          bar_nxt = BAR_OFF;
        end else if (value <= thr_mid_x) begin
          bar_nxt = BAR_ONE;
        end else if (value >= thr_mid_x && value <= thr_high_x) begin
          bar_nxt = BAR_THREE;
        end else if (value >= thr_high_x && value <= upper_lim_r) begin
          bar_nxt = BAR_SEVEN;
        end
      end
      case (bar_nxt)
        BAR_OFF:   digit_nxt = DIGIT_OFF;
        BAR_ONE:   digit_nxt = DIGIT_ONE;
        BAR_THREE: digit_nxt = DIGIT_THREE;
        BAR_SEVEN: digit_nxt = DIGIT_SEVEN;
        default:   digit_nxt = digit_r;
      endcase
      if (s1_select_r[2]) begin
        disp_nxt = sat_show(max_nxt);
      end else if (s1_select_r[1]) begin
        disp_nxt = sat_show(value);
      end else if (s1_select_r[0]) begin
        disp_nxt = sat_show(min_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      sum_r   <= '0;
      min_r   <= MIN_RESET;
      max_r   <= '0;
      bar_r   <= BAR_OFF;
      lamp_r  <= 1'b0;
      digit_r <= DIGIT_OFF;
      disp_r  <= '0;
    end else if (s2_go) begin
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      bar_r   <= bar_nxt;
      lamp_r  <= lamp_nxt;
      digit_r <= digit_nxt;
      disp_r  <= disp_nxt;
    end
  end

  // ---------------- Result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= block_done;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && block_done) begin
      out_value_r <= value;
    end
  end

  // Bar, lamp, level digit and display live in the state registers, which only move
  // when a new result is loaded, so the result reads them directly; the mode digit follows manual_r.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sensor_value = out_value_r;
  assign out_ch.level_bar    = bar_r;
  assign out_ch.lamp_on      = lamp_r;
  assign out_ch.mode_digit   = !manual_r;
  assign out_ch.level_digit  = digit_r;
  assign out_ch.shown_number = disp_r;

endmodule
